// ===== design/m4p_pkg.sv =====
// Package for the 4x4 Q16.16 matrix product: sizes, constants and payload types.
package m4p_pkg;

   localparam int DIM             = 4;
   localparam int ELEM_W          = 32;
   localparam int IDX_W           = 2;
   localparam int PROD_W          = 2 * ELEM_W;
   localparam int ACC_W           = PROD_W + 2;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef elem_type [DIM-1:0] row_type;

   localparam elem_type ELEM_MAX = 32'sh7FFF_FFFF;
   localparam elem_type ELEM_MIN = 32'sh8000_0000;

   // one request: a row of the left matrix and the same row of the right matrix
   typedef struct packed {
      logic signed [ELEM_W-1:0] left_e0;
      logic signed [ELEM_W-1:0] left_e1;
      logic signed [ELEM_W-1:0] left_e2;
      logic signed [ELEM_W-1:0] left_e3;
      logic signed [ELEM_W-1:0] right_e0;
      logic signed [ELEM_W-1:0] right_e1;
      logic signed [ELEM_W-1:0] right_e2;
      logic signed [ELEM_W-1:0] right_e3;
   } req_type;

   // one product row
   typedef struct packed {
      logic [IDX_W-1:0]         row_number;
      logic signed [ELEM_W-1:0] prod_e0;
      logic signed [ELEM_W-1:0] prod_e1;
      logic signed [ELEM_W-1:0] prod_e2;
      logic signed [ELEM_W-1:0] prod_e3;
      logic                     last_row;
   } rsp_type;

   // queue entry: request tagged with its row index
   typedef struct packed {
      logic [IDX_W-1:0] row;
      req_type          data;
   } qent_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== design/m4p_front.sv =====
// Front end: accepts requests, tags each with its row index and pushes it to the queue.
module m4p_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  m4p_pkg::req_type    req_data,
   input  m4p_pkg::qstat_type  q_stat,
   output logic                q_push,
   output m4p_pkg::qent_type   q_entry
);
   import m4p_pkg::*;

   logic [IDX_W-1:0] row_cnt_ff, row_cnt_in;

   // take a request whenever the queue has room
   assign req_stall = q_stat.full;
   assign q_push    = req_valid & ~q_stat.full;

   // row index of the next request within its group of four
   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (q_push) begin
         row_cnt_in = (row_cnt_ff == LAST_IDX) ? '0 : row_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
      end
   end

   assign q_entry.row  = row_cnt_ff;
   assign q_entry.data = req_data;

endmodule

// ===== design/m4p_queue.sv =====
// Short FIFO between front end and compute back end.
module m4p_queue #(
   parameter int DEPTH = m4p_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  m4p_pkg::qent_type   push_entry,
   input  logic                pop,
   output m4p_pkg::qent_type   head,
   output m4p_pkg::qstat_type  stat
);
   import m4p_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qent_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/m4p_back.sv =====
// Back end: row stores, four multiply-accumulate lanes, saturation and result register.
module m4p_back #(
   parameter int FRAC_BITS = m4p_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  m4p_pkg::qstat_type  q_stat,
   input  m4p_pkg::qent_type   q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output m4p_pkg::rsp_type    rsp_data
);
   import m4p_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(ELEM_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(ELEM_MIN);

   // rows 0..2 of the group being loaded; row 3 comes straight from the queue
   row_type ld_a_ff [DIM-1];
   row_type ld_b_ff [DIM-1];
   // matrices of the group being computed
   row_type cm_a_ff [DIM];
   row_type cm_b_ff [DIM];
   row_type head_a, head_b;

   logic             start, load, adv, wr_rsp;
   logic             issuing_ff, issuing_in;
   logic [IDX_W-1:0] i_ff, i_in, k_ff, k_in;

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic                     p_vld_ff, p_vld_in;
   logic                     p_first_ff, p_last_ff;
   logic [IDX_W-1:0]         p_row_ff;

   logic signed [ACC_W-1:0]  acc_ff [DIM];
   logic signed [ACC_W-1:0]  sum [DIM];

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   // floor shift and clamp to the 32-bit signed range
   function automatic elem_type sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v >>> FRAC_BITS;
      if (s > SAT_HI) begin
         return ELEM_MAX;
      end else if (s < SAT_LO) begin
         return ELEM_MIN;
      end else begin
         return s[ELEM_W-1:0];
      end
   endfunction

   always_comb begin
      head_a[0] = q_head.data.left_e0;
      head_a[1] = q_head.data.left_e1;
      head_a[2] = q_head.data.left_e2;
      head_a[3] = q_head.data.left_e3;
      head_b[0] = q_head.data.right_e0;
      head_b[1] = q_head.data.right_e1;
      head_b[2] = q_head.data.right_e2;
      head_b[3] = q_head.data.right_e3;
   end

   // row 3 may only be taken once the previous group has finished issuing
   assign q_pop = ~q_stat.empty & ((q_head.row != LAST_IDX) | ~issuing_ff);
   assign start = q_pop & (q_head.row == LAST_IDX);
   assign load  = q_pop & (q_head.row != LAST_IDX);

   // the compute pipe holds while a finished row cannot enter the result register
   assign wr_rsp = p_vld_ff & p_last_ff;
   assign adv    = ~wr_rsp | ~rsp_vld_ff | ~rsp_stall;

   // load bank
   always_ff @(posedge clock) begin
      if (load) begin
         ld_a_ff[q_head.row] <= head_a;
         ld_b_ff[q_head.row] <= head_b;
      end
   end

   // compute bank, copied whole when the fourth row arrives
   always_ff @(posedge clock) begin
      if (start) begin
         for (int r = 0; r < DIM - 1; r++) begin
            cm_a_ff[r] <= ld_a_ff[r];
            cm_b_ff[r] <= ld_b_ff[r];
         end
         cm_a_ff[DIM-1] <= head_a;
         cm_b_ff[DIM-1] <= head_b;
      end
   end

   // issue sequencer: product row i, inner index k
   always_comb begin
      issuing_in = issuing_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      if (start) begin
         issuing_in = 1'b1;
         i_in       = '0;
         k_in       = '0;
      end else if (adv && issuing_ff) begin
         k_in = (k_ff == LAST_IDX) ? '0 : k_ff + 1'b1;
         if (k_ff == LAST_IDX) begin
            i_in = (i_ff == LAST_IDX) ? '0 : i_ff + 1'b1;
            if (i_ff == LAST_IDX) begin
               issuing_in = 1'b0;
            end
         end
      end
   end

   assign p_vld_in = adv ? issuing_ff : p_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         i_ff       <= '0;
         k_ff       <= '0;
         p_vld_ff   <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         i_ff       <= i_in;
         k_ff       <= k_in;
         p_vld_ff   <= p_vld_in;
      end
   end

   // multiply stage: A[i][k] times row k of B, one lane per column
   always_ff @(posedge clock) begin
      if (adv && issuing_ff) begin
         for (int j = 0; j < DIM; j++) begin
            prod_ff[j] <= $signed(cm_a_ff[i_ff][k_ff]) * $signed(cm_b_ff[k_ff][j]);
         end
         p_first_ff <= (k_ff == '0);
         p_last_ff  <= (k_ff == LAST_IDX);
         p_row_ff   <= i_ff;
      end
   end

   // accumulate stage, exact sum of four products
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         sum[j] = (p_first_ff ? '0 : acc_ff[j]) + ACC_W'(prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p_vld_ff && !p_last_ff) begin
         for (int j = 0; j < DIM; j++) begin
            acc_ff[j] <= sum[j];
         end
      end
   end

   // result register
   always_comb begin
      rsp_in.row_number = p_row_ff;
      rsp_in.prod_e0    = sat(sum[0]);
      rsp_in.prod_e1    = sat(sum[1]);
      rsp_in.prod_e2    = sat(sum[2]);
      rsp_in.prod_e3    = sat(sum[3]);
      rsp_in.last_row   = (p_row_ff == LAST_IDX);
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (adv && wr_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && wr_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/matrix4_product.sv =====
// Top level of the 4x4 Q16.16 matrix product.
// The fourth request of a group starts the issue sequencer; each product row then passes
// the multiply register and, summed with the accumulator, the result register (four MAC
// lanes, one inner index per cycle while a held result does not stall the pipe). Rows 0..2
// of the next group load while a group computes; its fourth row waits until issuing ends.
// Reset (synchronous): empties the queue, clears row count, issue state and result valid.
module matrix4_product #(
   parameter int FRAC_BITS   = m4p_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = m4p_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  m4p_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output m4p_pkg::rsp_type  rsp_data
);
   import m4p_pkg::*;

   qstat_type q_stat;
   qent_type  q_entry, q_head;
   logic      q_push, q_pop;

   m4p_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   m4p_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   m4p_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // a full queue with no pop stays full
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      q_stat.full && !q_pop |=> q_stat.full)
      else $error("queue left full state without a pop");

   // last flag marks exactly the final product row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_number == LAST_IDX)))
      else $error("last_row does not match row_number");

endmodule
